>>> rtl/scf_pkg.sv
// Package for the scaled fixed-point to binary32 converter.
// Holds the stage record types, the format constants and the leading-zero count.
// No dependencies.
package scf_pkg;

    localparam int unsigned WordW = 32;
    localparam int unsigned ExpW = 9;
    localparam int unsigned LzW = 5;
    localparam int unsigned BexpW = 11;

    localparam logic [WordW-1:0] SignBit = 32'h8000_0000;
    localparam logic [WordW-1:0] InfBits = 32'h7F80_0000;
    localparam logic [WordW-1:0] MantReset = 32'h8000_0000;
    localparam logic [ExpW-1:0] ExpReset = 9'h1E1;
    localparam logic signed [BexpW-1:0] ExpOffset = 11'sd190;
    localparam logic signed [BexpW-1:0] ExpMax = 11'sd255;
    localparam logic signed [BexpW-1:0] DenormMin = -11'sd22;
    localparam logic signed [BexpW-1:0] DenormBase = 11'sd9;

    typedef enum logic {
        CFG_MANTISSA = 1'b0,
        CFG_EXPONENT = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic             sign;
        logic [WordW-1:0] mag;
    } t_s1;

    typedef struct packed {
        logic             sign;
        logic             zero;
        logic [LzW-1:0]   lz;
        logic [WordW-1:0] frac;
    } t_s2;

    typedef struct packed {
        logic             sign;
        logic             zero;
        logic [LzW-1:0]   lz;
        logic [WordW-1:0] prod;
    } t_s3;

    typedef struct packed {
        logic                    sign;
        logic                    zero;
        logic signed [BexpW-1:0] bexp;
        logic [WordW-1:0]        frac;
    } t_s4;

    function automatic logic [LzW-1:0] lead_zeros(input logic [WordW-1:0] x);
        logic [LzW-1:0] n;
        n = '0;
        for (int i = 0; i < WordW; i++) begin
            if (x[i]) begin
                n = LzW'(WordW - 1 - i);
            end
        end
        return n;
    endfunction

endpackage

>>> rtl/scaled_fixed_to_float32_core.sv
// Scaled fixed-point to IEEE 754 binary32 converter, top level.
// Throughput is one request per cycle while i_stall does not hold the output,
// set by the five-stage pipeline in which each stage holds until the next one
// frees. Each stage advances on its own, so bubbles close up.
// Reset (synchronous, active low) clears all valid bits and loads the scale
// registers with mantissa 0x80000000 and exponent -31. Uses scf_pkg.
module scaled_fixed_to_float32_core import scf_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [WordW-1:0] i_cfg_data,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic             i_mode,
    input  logic [WordW-1:0] i_value,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [WordW-1:0] o_float_bits
);

    localparam int unsigned Stages = 5;

    logic [WordW-1:0]  r_mant;
    logic [ExpW-1:0]   r_exp;
    logic [Stages-1:0] r_v;
    logic [Stages-1:0] rdy;
    t_s2               s2;
    t_s3               s3;

    always_comb begin
        rdy[Stages-1] = !r_v[Stages-1] || !i_stall;
        for (int k = Stages - 2; k >= 0; k--) begin
            rdy[k] = !r_v[k] || rdy[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v    <= '0;
            r_mant <= MantReset;
            r_exp  <= ExpReset;
        end else begin
            if (rdy[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < Stages; k++) begin
                if (rdy[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_MANTISSA: begin
                        r_mant <= i_cfg_data;
                    end
                    CFG_EXPONENT: begin
                        r_exp <= i_cfg_data[ExpW-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    scf_norm u_norm (
        .i_clk   (i_clk),
        .i_en1   (rdy[0]),
        .i_en2   (rdy[1]),
        .i_mode  (i_mode),
        .i_value (i_value),
        .o_s2    (s2)
    );

    scf_mult u_mult (
        .i_clk  (i_clk),
        .i_en   (rdy[2]),
        .i_mant (r_mant),
        .i_s2   (s2),
        .o_s3   (s3)
    );

    scf_pack u_pack (
        .i_clk  (i_clk),
        .i_en4  (rdy[3]),
        .i_en5  (rdy[4]),
        .i_exp  (r_exp),
        .i_s3   (s3),
        .o_bits (o_float_bits)
    );

    assign o_stall = !rdy[0];
    assign o_valid = r_v[Stages-1];

endmodule

>>> rtl/scf_norm.sv
// Front stages: sign and magnitude, then leading-zero count and normalization.
// Depends on scf_pkg.
module scf_norm import scf_pkg::*; (
    input  logic             i_clk,
    input  logic             i_en1,
    input  logic             i_en2,
    input  logic             i_mode,
    input  logic [WordW-1:0] i_value,
    output t_s2              o_s2
);

    t_s1 r_s1;
    t_s1 n_s1;
    t_s2 r_s2;
    t_s2 n_s2;

    always_comb begin
        n_s1.sign = i_mode & i_value[WordW-1];
        n_s1.mag  = n_s1.sign ? (~i_value + WordW'(1)) : i_value;
    end

    always_comb begin
        n_s2.sign = r_s1.sign;
        n_s2.zero = (r_s1.mag == '0);
        n_s2.lz   = lead_zeros(r_s1.mag);
        n_s2.frac = r_s1.mag << n_s2.lz;
    end

    always_ff @(posedge i_clk) begin
        if (i_en1) begin
            r_s1 <= n_s1;
        end
        if (i_en2) begin
            r_s2 <= n_s2;
        end
    end

    assign o_s2 = r_s2;

endmodule

>>> rtl/scf_mult.sv
// Scale multiply stage: normalized magnitude times the scale mantissa, high word kept.
// Depends on scf_pkg.
module scf_mult import scf_pkg::*; (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [WordW-1:0] i_mant,
    input  t_s2              i_s2,
    output t_s3              o_s3
);

    t_s3              r_s3;
    t_s3              n_s3;
    logic [2*WordW-1:0] full;

    always_comb begin
        full       = (2*WordW)'(i_s2.frac) * (2*WordW)'(i_mant);
        n_s3.sign  = i_s2.sign;
        n_s3.zero  = i_s2.zero;
        n_s3.lz    = i_s2.lz;
        n_s3.prod  = full[2*WordW-1:WordW];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s3 <= n_s3;
        end
    end

    assign o_s3 = r_s3;

endmodule

>>> rtl/scf_pack.sv
// Back stages: renormalize the product and form the exponent, then pack binary32.
// Depends on scf_pkg.
module scf_pack import scf_pkg::*; (
    input  logic             i_clk,
    input  logic             i_en4,
    input  logic             i_en5,
    input  logic [ExpW-1:0]  i_exp,
    input  t_s3              i_s3,
    output logic [WordW-1:0] o_bits
);

    t_s4                     r_s4;
    t_s4                     n_s4;
    logic [WordW-1:0]        r_bits;
    logic [WordW-1:0]        n_bits;
    logic [LzW-1:0]          lz2;
    logic [WordW:0]          wide;
    logic signed [BexpW-1:0] dsh_full;
    logic [LzW-1:0]          dsh;
    logic [WordW-1:0]        dfrac;

    always_comb begin
        lz2        = lead_zeros(i_s3.prod);
        wide       = {i_s3.prod, 1'b0} << lz2;
        n_s4.sign  = i_s3.sign;
        n_s4.zero  = i_s3.zero | (i_s3.prod == '0);
        n_s4.frac  = wide[WordW-1:0];
        n_s4.bexp  = ExpOffset + $signed({{(BexpW-ExpW){i_exp[ExpW-1]}}, i_exp})
                     - $signed({{(BexpW-LzW){1'b0}}, i_s3.lz})
                     - $signed({{(BexpW-LzW){1'b0}}, lz2});
    end

    always_comb begin
        dsh_full = DenormBase - r_s4.bexp;
        dsh      = dsh_full[LzW-1:0];
        dfrac    = ((r_s4.frac >> 1) | SignBit) >> dsh;
        if (r_s4.zero) begin
            n_bits = {r_s4.sign, {(WordW-1){1'b0}}};
        end else if (r_s4.bexp >= ExpMax) begin
            n_bits = InfBits | {r_s4.sign, {(WordW-1){1'b0}}};
        end else if (r_s4.bexp <= 0) begin
            if (r_s4.bexp < DenormMin) begin
                n_bits = {r_s4.sign, {(WordW-1){1'b0}}};
            end else begin
                n_bits = dfrac | {r_s4.sign, {(WordW-1){1'b0}}};
            end
        end else begin
            n_bits = {r_s4.sign, r_s4.bexp[7:0], r_s4.frac[WordW-1:9]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en4) begin
            r_s4 <= n_s4;
        end
        if (i_en5) begin
            r_bits <= n_bits;
        end
    end

    assign o_bits = r_bits;

endmodule

>>> verif/tb_scaled_fixed_to_float32_core.sv
`timescale 1ns / 100ps
// Self-checking testbench for scaled_fixed_to_float32_core: drives fixed-point requests under
// several scale settings and checks every binary32 result against an in-bench predictor.
// Depends on scf_pkg and the core RTL.
module tb_scaled_fixed_to_float32_core;
    import scf_pkg::*;

    localparam int FloatBias = 127;
    localparam int NumPhases = 12;
    localparam int IdleLimit = 2000;
    localparam logic [WordW-1:0] CornerWords [6] = '{
        32'h0000_0000, 32'h0000_0001, 32'h7FFF_FFFF,
        32'h8000_0000, 32'hFFFF_FFFF, 32'h0001_0000
    };

    typedef enum logic [1:0] {
        ENT_REQUEST,
        ENT_CFG_WRITE,
        ENT_DRAIN
    } t_entry_kind;

    typedef struct {
        t_entry_kind      kind;
        logic             mode;
        logic [WordW-1:0] value;
        t_cfg_idx         idx;
        logic [WordW-1:0] data;
        int               gap;
    } t_entry;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_cfg_we = 1'b0;
    logic             i_cfg_idx = 1'b0;
    logic [WordW-1:0] i_cfg_data = '0;
    logic             i_valid = 1'b0;
    logic             o_stall;
    logic             i_mode = 1'b0;
    logic [WordW-1:0] i_value = '0;
    logic             o_valid;
    logic             i_stall = 1'b0;
    logic [WordW-1:0] o_float_bits;

    t_entry           conv_work_q[$];
    logic [WordW-1:0] pending_float_q[$];
    logic [WordW-1:0] cur_mantissa = MantReset;
    logic [ExpW-1:0]  cur_exponent = ExpReset;
    int               send_wait = 0;
    logic             gap_armed = 1'b0;
    int               rx_wait = 0;
    logic             rx_calm = 1'b0;
    int               requests_sent = 0;
    int               cfg_writes = 0;
    int               results_seen = 0;
    int               error_count = 0;
    int               idle_cycles = 0;

    scaled_fixed_to_float32_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_mode       (i_mode),
        .i_value      (i_value),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_float_bits (o_float_bits)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic int count_leading_zeros(input logic [WordW-1:0] x);
        int n;
        n = 0;
        while (n < 32 && !x[31-n]) n++;
        return n;
    endfunction

    function automatic logic [WordW-1:0] fixed_to_float_bits(
        input logic             mode,
        input logic [WordW-1:0] value,
        input logic [WordW-1:0] mant,
        input logic [ExpW-1:0]  sexp
    );
        logic [WordW-1:0] sign_mask;
        logic [WordW-1:0] mag;
        logic [WordW-1:0] frac;
        logic [63:0]      prod;
        int               shift;
        int               fix;
        int               bexp;
        sign_mask = (mode && value[31]) ? SignBit : '0;
        mag = (mode && value[31]) ? (32'd0 - value) : value;
        if (mag == '0) return sign_mask;
        shift = count_leading_zeros(mag);
        frac = mag << shift;
        prod = {32'd0, frac} * {32'd0, mant};
        frac = prod[63:32];
        if (frac == '0) return sign_mask;
        fix = count_leading_zeros(frac) + 1;
        frac = (fix >= 32) ? '0 : (frac << fix);
        shift += fix;
        bexp = FloatBias + 64 + int'($signed(sexp)) - shift;
        if (bexp <= 0) begin
            if (bexp < -22) return sign_mask;
            frac = (frac >> 1) | SignBit;
            return sign_mask | (frac >> (9 - bexp));
        end
        if (bexp >= 255) return sign_mask | InfBits;
        return sign_mask | {1'b0, 8'(bexp), frac[31:9]};
    endfunction

    task automatic add_request(input logic mode, input logic [WordW-1:0] value, input logic calm);
        t_entry e;
        e.kind = ENT_REQUEST;
        e.mode = mode;
        e.value = value;
        e.idx = CFG_MANTISSA;
        e.data = '0;
        e.gap = calm ? 0 : int'($urandom_range(0, 12));
        conv_work_q.push_back(e);
    endtask

    task automatic add_control(input t_entry_kind kind, input t_cfg_idx idx,
                               input logic [WordW-1:0] data);
        t_entry e;
        e.kind = kind;
        e.mode = 1'b0;
        e.value = '0;
        e.idx = idx;
        e.data = data;
        e.gap = 0;
        conv_work_q.push_back(e);
    endtask

    always @(posedge i_clk) begin : request_driver
        logic             nxt_valid;
        logic             nxt_mode;
        logic [WordW-1:0] nxt_value;
        logic             nxt_we;
        logic             nxt_idx;
        logic [WordW-1:0] nxt_data;
        nxt_valid = i_valid;
        nxt_mode = i_mode;
        nxt_value = i_value;
        nxt_we = 1'b0;
        nxt_idx = i_cfg_idx;
        nxt_data = i_cfg_data;
        if (!i_rst_n) begin
            cur_mantissa = MantReset;
            cur_exponent = ExpReset;
            nxt_valid = 1'b0;
            gap_armed = 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                pending_float_q.push_back(
                    fixed_to_float_bits(i_mode, i_value, cur_mantissa, cur_exponent));
                void'(conv_work_q.pop_front());
                requests_sent++;
                nxt_valid = 1'b0;
            end
            if (!nxt_valid && conv_work_q.size() > 0) begin
                case (conv_work_q[0].kind)
                    ENT_REQUEST: begin
                        if (!gap_armed) begin
                            send_wait = conv_work_q[0].gap;
                            gap_armed = 1'b1;
                        end
                        if (send_wait > 0) begin
                            send_wait--;
                        end else begin
                            gap_armed = 1'b0;
                            nxt_valid = 1'b1;
                            nxt_mode = conv_work_q[0].mode;
                            nxt_value = conv_work_q[0].value;
                        end
                    end
                    ENT_CFG_WRITE: begin
                        if (pending_float_q.size() == 0) begin
                            nxt_we = 1'b1;
                            nxt_idx = conv_work_q[0].idx;
                            nxt_data = conv_work_q[0].data;
                            if (conv_work_q[0].idx == CFG_MANTISSA) begin
                                cur_mantissa = conv_work_q[0].data;
                            end else begin
                                cur_exponent = conv_work_q[0].data[ExpW-1:0];
                            end
                            cfg_writes++;
                            void'(conv_work_q.pop_front());
                        end
                    end
                    default: begin
                        if (pending_float_q.size() == 0) begin
                            void'(conv_work_q.pop_front());
                        end
                    end
                endcase
            end
        end
        i_valid <= nxt_valid;
        i_mode <= nxt_mode;
        i_value <= nxt_value;
        i_cfg_we <= nxt_we;
        i_cfg_idx <= nxt_idx;
        i_cfg_data <= nxt_data;
    end

    always @(posedge i_clk) begin : result_monitor
        logic             nxt_stall;
        logic [WordW-1:0] want;
        nxt_stall = 1'b0;
        if (!i_rst_n) begin
            rx_wait = 0;
        end else begin
            if (o_valid && !i_stall) begin
                if (pending_float_q.size() == 0) begin
                    $error("float_bits: no result expected, actual %h", o_float_bits);
                    error_count++;
                end else begin
                    want = pending_float_q.pop_front();
                    if (o_float_bits !== want) begin
                        $error("float_bits: expected %h, actual %h", want, o_float_bits);
                        error_count++;
                    end
                end
                results_seen++;
                if (results_seen % 32 == 0) rx_calm = ($urandom_range(0, 2) == 0);
                rx_wait = rx_calm ? 0 : int'($urandom_range(0, 12));
            end else if (rx_wait > 0) begin
                rx_wait--;
            end
            nxt_stall = (rx_wait > 0);
        end
        i_stall <= nxt_stall;
    end

    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall) || i_cfg_we) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IdleLimit) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        logic [WordW-1:0] mant;
        logic [ExpW-1:0]  sexp;
        logic [WordW-1:0] v;
        logic             calm;
        int               n_rand;
        int               drain_at;
        calm = 1'b0;
        for (int p = 0; p < NumPhases; p++) begin
            case (p)
                0: begin
                    mant = MantReset;
                    sexp = ExpReset;
                end
                1: begin
                    mant = 32'hFFFF_FFFF;
                    sexp = 9'sd97;
                end
                2: begin
                    mant = 32'h8000_0000;
                    sexp = -9'sd158;
                end
                3: begin
                    mant = 32'h0000_0001;
                    sexp = 9'sd0;
                end
                4: begin
                    mant = 32'h0001_2345;
                    sexp = -9'sd40;
                end
                5: begin
                    mant = 32'hC000_0000;
                    sexp = -9'sd140;
                end
                default: begin
                    mant = SignBit | $urandom;
                    sexp = 9'(int'($urandom_range(0, 255)) - 158);
                end
            endcase
            if (p != 0) begin
                add_control(ENT_CFG_WRITE, CFG_MANTISSA, mant);
                add_control(ENT_CFG_WRITE, CFG_EXPONENT, {23'd0, sexp});
            end
            if (p == 0) begin
                for (int k = 0; k < 6; k++) begin
                    add_request(1'b0, CornerWords[k], 1'b0);
                    add_request(1'b1, CornerWords[k], 1'b0);
                end
            end else if (p == 1) begin
                add_request(1'b0, 32'hFFFF_FFFF, 1'b0);
                add_request(1'b1, 32'h8000_0000, 1'b0);
                add_request(1'b0, 32'h0000_0001, 1'b0);
            end else if (p == 2) begin
                add_request(1'b0, 32'h0000_0001, 1'b0);
                add_request(1'b0, 32'hFFFF_FFFF, 1'b0);
                add_request(1'b1, 32'hFFFF_FFFF, 1'b0);
                add_request(1'b1, 32'h8000_0000, 1'b0);
            end
            n_rand = (p == 3) ? 24 : 129;
            drain_at = $urandom_range(0, n_rand - 1);
            for (int i = 0; i < n_rand; i++) begin
                if (i % 32 == 0) calm = ($urandom_range(0, 3) == 0);
                if (i == drain_at) add_control(ENT_DRAIN, CFG_MANTISSA, '0);
                case ($urandom_range(0, 3))
                    0: v = $urandom;
                    1: v = $urandom >> $urandom_range(0, 31);
                    2: v = 32'd0 - ($urandom >> $urandom_range(0, 31));
                    default: v = 32'd1 << $urandom_range(0, 31);
                endcase
                add_request(1'($urandom_range(0, 1)), v, calm);
            end
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (conv_work_q.size() != 0 || pending_float_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("Converted %0d signed and unsigned requests under %0d scale settings.",
                 requests_sent, NumPhases);
        $display("%0d register writes, %0d results compared, %0d mismatches.",
                 cfg_writes, results_seen, error_count);
        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/scf_pkg.sv
rtl/scf_norm.sv
rtl/scf_mult.sv
rtl/scf_pack.sv
rtl/scaled_fixed_to_float32_core.sv
verif/tb_scaled_fixed_to_float32_core.sv
